// File: src/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an expression is never true outside reset.
`define ASSERT_NEVER(lbl, expr, msg) \
  `ASSERT_CLK(lbl, !(expr), msg)

`endif

// File: src/iat_pkg.sv
// Types, constants and helpers for the integer to ASCII text converter.
package iat_pkg;

  localparam int VALUE_W    = 64;
  localparam int FUNC_W     = 2;
  localparam int CHAR_W     = 8;
  localparam int LEN_W      = 5;
  localparam int NUM_DIGITS = 20;
  localparam int DIGIT_W    = 4;
  localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
  localparam int CNT_W      = 6;

  localparam logic [FUNC_W-1:0] FUNC_UDEC    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SDEC    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_HEX     = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_HEX_ALT = 2'd3;
  localparam int FUNC_HEX_BIT = 1;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] ASCII_A     = 8'h41;
  localparam logic [DIGIT_W-1:0] DEC_BASE   = 4'd10;

  localparam logic [CNT_W-1:0] CONV_LAST = 6'd63;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_NORM,
    ST_SIGN,
    ST_EMIT
  } iat_state_t;

  typedef struct packed {
    logic load;
    logic conv_step;
    logic norm_step;
    logic latch_len;
    logic emit_sign;
    logic emit_digit;
  } iat_cmd_t;

  typedef struct packed {
    logic conv_done;
    logic norm_done;
    logic neg;
    logic last_digit;
    logic out_free;
  } iat_sts_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] res;
    if (d < DEC_BASE) begin
      res = ASCII_ZERO + {4'd0, d};
    end else begin
      res = ASCII_A + {4'd0, d - DEC_BASE};
    end
    return res;
  endfunction

endpackage

// File: src/iat_dp.sv
// Datapath: double-dabble converter, digit shifter and output register.
module iat_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [iat_pkg::FUNC_W-1:0]    in_func,
  input  logic [iat_pkg::VALUE_W-1:0]   in_value,
  input  iat_pkg::iat_cmd_t             cmd,
  output iat_pkg::iat_sts_t             sts,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [iat_pkg::CHAR_W-1:0]    out_character,
  output logic                          out_last,
  output logic [iat_pkg::LEN_W-1:0]     out_length
);

  localparam int BW = iat_pkg::BCD_W;
  localparam int DW = iat_pkg::DIGIT_W;

  logic [iat_pkg::VALUE_W-1:0] bin_r;
  logic [BW-1:0]               bcd_r;
  logic [BW-1:0]               bcd_adj;
  logic                        neg_r;
  logic                        neg_in;
  logic [iat_pkg::LEN_W-1:0]   ndig_r;
  logic [iat_pkg::LEN_W-1:0]   len_r;
  logic [iat_pkg::CNT_W-1:0]   cnt_r;
  logic [DW-1:0]               top_dig;
  logic                        out_valid_r;
  logic                        out_valid_nxt;
  logic [iat_pkg::CHAR_W-1:0]  char_r;
  logic                        last_r;
  logic [iat_pkg::LEN_W-1:0]   olen_r;

  assign neg_in  = (in_func == iat_pkg::FUNC_SDEC) && in_value[iat_pkg::VALUE_W-1];
  assign top_dig = bcd_r[BW-1 -: DW];

  always_comb begin
    for (int i = 0; i < iat_pkg::NUM_DIGITS; i++) begin
      bcd_adj[i*DW +: DW] = (bcd_r[i*DW +: DW] >= 4'd5) ?
                            bcd_r[i*DW +: DW] + 4'd3 : bcd_r[i*DW +: DW];
    end
  end

  assign sts.conv_done  = (cnt_r == iat_pkg::CONV_LAST);
  assign sts.norm_done  = (ndig_r == 5'd1) || (top_dig != '0);
  assign sts.neg        = neg_r;
  assign sts.last_digit = (ndig_r == 5'd1);
  assign sts.out_free   = !out_valid_r || out_ready;

  // Load, conversion, digit shifting and length latch.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin_r  <= neg_in ? (~in_value + 64'd1) : in_value;
      neg_r  <= neg_in;
      bcd_r  <= in_func[iat_pkg::FUNC_HEX_BIT] ? {16'd0, in_value} : '0;
      ndig_r <= iat_pkg::LEN_W'(iat_pkg::NUM_DIGITS);
      cnt_r  <= '0;
    end else if (cmd.conv_step) begin
      bcd_r <= {bcd_adj[BW-2:0], bin_r[iat_pkg::VALUE_W-1]};
      bin_r <= {bin_r[iat_pkg::VALUE_W-2:0], 1'b0};
      cnt_r <= cnt_r + 6'd1;
    end else if (cmd.norm_step || cmd.emit_digit) begin
      bcd_r  <= {bcd_r[BW-DW-1:0], {DW{1'b0}}};
      ndig_r <= ndig_r - 5'd1;
    end
    if (cmd.latch_len) begin
      len_r <= ndig_r + {4'd0, neg_r};
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit_sign || cmd.emit_digit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load the output word.
  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      char_r <= iat_pkg::ASCII_MINUS;
      last_r <= 1'b0;
      olen_r <= len_r;
    end else if (cmd.emit_digit) begin
      char_r <= iat_pkg::digit_char(top_dig);
      last_r <= (ndig_r == 5'd1);
      olen_r <= len_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_character = char_r;
  assign out_last      = last_r;
  assign out_length    = olen_r;

endmodule

// File: src/iat_ctrl.sv
// Controller state machine: load, convert, strip leading zeros, emit.
module iat_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_hex,
  output logic              in_ready,
  input  iat_pkg::iat_sts_t sts,
  output iat_pkg::iat_cmd_t cmd
);

  iat_pkg::iat_state_t state_r;
  iat_pkg::iat_state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      iat_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = in_hex ? iat_pkg::ST_NORM : iat_pkg::ST_CONV;
        end
      end
      iat_pkg::ST_CONV: begin
        if (sts.conv_done) begin
          state_nxt = iat_pkg::ST_NORM;
        end
      end
      iat_pkg::ST_NORM: begin
        if (sts.norm_done) begin
          state_nxt = sts.neg ? iat_pkg::ST_SIGN : iat_pkg::ST_EMIT;
        end
      end
      iat_pkg::ST_SIGN: begin
        if (sts.out_free) begin
          state_nxt = iat_pkg::ST_EMIT;
        end
      end
      iat_pkg::ST_EMIT: begin
        if (sts.out_free && sts.last_digit) begin
          state_nxt = iat_pkg::ST_IDLE;
        end
      end
      default: state_nxt = iat_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      iat_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      iat_pkg::ST_CONV: begin
        cmd.conv_step = 1'b1;
      end
      iat_pkg::ST_NORM: begin
        cmd.latch_len = sts.norm_done;
        cmd.norm_step = !sts.norm_done;
      end
      iat_pkg::ST_SIGN: begin
        cmd.emit_sign = sts.out_free;
      end
      iat_pkg::ST_EMIT: begin
        cmd.emit_digit = sts.out_free;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= iat_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: src/integer_to_ascii_text_core.sv
// Top level of the integer to ASCII text converter.
//
//   channel | ports                                       | handshake
//   --------+---------------------------------------------+---------------------
//   input   | in_func, in_value                           | in_valid / in_ready
//   result  | out_character, out_last, out_length         | out_valid / out_ready
//
// One number at a time: a load, one shift-and-add-3 step per value bit in the
// double-dabble loop (skipped for hex), the leading-zero strip, then one
// character per cycle through the output register while out_ready does not stall.
// Reset clears the controller and the output valid flag only.
// A stalled out_ready holds the emission; the last character may wait while
// the next number is accepted.
`include "assert_macros.svh"

module integer_to_ascii_text_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [iat_pkg::FUNC_W-1:0]    in_func,
  input  logic [iat_pkg::VALUE_W-1:0]   in_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [iat_pkg::CHAR_W-1:0]    out_character,
  output logic                          out_last,
  output logic [iat_pkg::LEN_W-1:0]     out_length
);

  iat_pkg::iat_cmd_t cmd;
  iat_pkg::iat_sts_t sts;

  iat_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_hex   (in_func[iat_pkg::FUNC_HEX_BIT]),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  iat_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_func       (in_func),
    .in_value      (in_value),
    .cmd           (cmd),
    .sts           (sts),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .out_character (out_character),
    .out_last      (out_last),
    .out_length    (out_length)
  );

  `ASSERT_CLK(a_busy_after_accept, (in_valid && in_ready) |=> !in_ready, "busy after accept")
  `ASSERT_CLK(a_cmd_onehot, $onehot0(cmd), "datapath commands overlap")
  `ASSERT_NEVER(a_emit_full, (cmd.emit_sign || cmd.emit_digit) && !sts.out_free, "emit while full")
  `ASSERT_CLK(a_len_range, out_valid |-> (out_length != '0 && out_length <= 5'd20), "bad length")

endmodule

// File: dv/integer_to_ascii_text_core_test.sv
// Testbench for the integer to ASCII text converter: directed and random numbers, scoreboarded.
`timescale 1ns / 100ps

module integer_to_ascii_text_core_test;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int DRAIN_CYCLES  = 100;
  localparam int HOLD_CYCLES   = 600;
  localparam int RANDOM_CHUNK  = 100;

  typedef struct {
    logic [iat_pkg::CHAR_W-1:0] glyph;
    logic                       last_flag;
    logic [iat_pkg::LEN_W-1:0]  len;
  } text_char_t;

  class text_scoreboard;
    text_char_t pending_chars[$];
    int         errors;

    function new();
      errors = 0;
    endfunction

    function void note_number(logic [iat_pkg::FUNC_W-1:0] func,
                              logic [iat_pkg::VALUE_W-1:0] value);
      string                       glyphs;
      logic [iat_pkg::CHAR_W-1:0]  rev[$];
      logic [iat_pkg::VALUE_W-1:0] mag;
      logic                        neg;
      int                          n;
      text_char_t                  w;
      glyphs = "0123456789ABCDEF";
      mag = value;
      neg = 1'b0;
      if (func[iat_pkg::FUNC_HEX_BIT]) begin
        do begin
          rev.push_back(glyphs[mag[3:0]]);
          mag = mag >> 4;
        end while (mag != 0);
      end else begin
        if (func == iat_pkg::FUNC_SDEC && value[iat_pkg::VALUE_W-1]) begin
          neg = 1'b1;
          mag = ~value + 64'd1;
        end
        do begin
          rev.push_back(glyphs[mag % 64'd10]);
          mag = mag / 64'd10;
        end while (mag != 0);
        if (neg) begin
          rev.push_back(iat_pkg::ASCII_MINUS);
        end
      end
      n = rev.size();
      for (int k = 0; k < n; k++) begin
        w.glyph     = rev[n - 1 - k];
        w.last_flag = (k == n - 1);
        w.len       = n[iat_pkg::LEN_W-1:0];
        pending_chars.push_back(w);
      end
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
      errors++;
    endtask

    task check_char(logic [iat_pkg::CHAR_W-1:0] ch, logic last,
                    logic [iat_pkg::LEN_W-1:0] len);
      text_char_t w;
      if (pending_chars.size() == 0) begin
        report("unexpected word, character", ch, 0);
        return;
      end
      w = pending_chars.pop_front();
      if (ch !== w.glyph) report("character", ch, w.glyph);
      if (last !== w.last_flag) report("last", last, w.last_flag);
      if (len !== w.len) report("length", len, w.len);
    endtask
  endclass

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  logic [iat_pkg::FUNC_W-1:0]   in_func;
  logic [iat_pkg::VALUE_W-1:0]  in_value;
  logic                         out_valid;
  logic                         out_ready;
  logic [iat_pkg::CHAR_W-1:0]   out_character;
  logic                         out_last;
  logic [iat_pkg::LEN_W-1:0]    out_length;

  text_scoreboard sb;
  int  src_idle = 0;
  int  sink_idle = 0;
  bit  hold_req = 1'b0;
  int  hold_left = 0;
  int  cycles = 0;

  integer_to_ascii_text_core uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_func       (in_func),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_character (out_character),
    .out_last      (out_last),
    .out_length    (out_length)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [iat_pkg::VALUE_W-1:0] rand_value();
    logic [iat_pkg::VALUE_W-1:0] v;
    logic [iat_pkg::VALUE_W-1:0] p;
    int                          pick;
    pick = $urandom_range(4);
    case (pick)
      0: v = {$urandom, $urandom};
      1: v = {$urandom, $urandom} >> $urandom_range(63);
      2: v = $urandom_range(999);
      3: begin
        p = 64'd1;
        repeat ($urandom_range(19)) p = p * 64'd10;
        v = p - $urandom_range(1);
      end
      default: v = -({32'd0, $urandom} >> $urandom_range(31));
    endcase
    return v;
  endfunction

  task send_number(logic [iat_pkg::FUNC_W-1:0] func, logic [iat_pkg::VALUE_W-1:0] value);
    while ($urandom_range(99) < src_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_func  <= func;
    in_value <= value;
    do begin
      @(posedge clk);
    end while (!in_ready);
    sb.note_number(func, value);
    @(negedge clk);
  endtask

  task send_random(int count);
    repeat (count) send_number(iat_pkg::FUNC_W'($urandom_range(3)), rand_value());
  endtask

  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= sink_idle);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_char(out_character, out_last, out_length);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    sb        = new();
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_func   = iat_pkg::FUNC_UDEC;
    in_value  = '0;
    out_ready = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    src_idle  = 13;
    sink_idle = 71;
    send_number(iat_pkg::FUNC_UDEC, 64'd0);
    send_number(iat_pkg::FUNC_UDEC, 64'd1);
    send_number(iat_pkg::FUNC_UDEC, 64'd9);
    send_number(iat_pkg::FUNC_UDEC, 64'd10);
    send_number(iat_pkg::FUNC_UDEC, 64'hFFFF_FFFF_FFFF_FFFF);
    send_number(iat_pkg::FUNC_UDEC, 64'd10000000000000000000);
    send_number(iat_pkg::FUNC_UDEC, 64'd9999999999999999999);
    send_number(iat_pkg::FUNC_UDEC, 64'h8000_0000_0000_0000);
    send_number(iat_pkg::FUNC_SDEC, 64'd0);
    send_number(iat_pkg::FUNC_SDEC, 64'd7);
    send_number(iat_pkg::FUNC_SDEC, 64'hFFFF_FFFF_FFFF_FFFF);
    send_number(iat_pkg::FUNC_SDEC, 64'hFFFF_FFFF_FFFF_FFF7);
    send_number(iat_pkg::FUNC_SDEC, 64'h8000_0000_0000_0000);
    send_number(iat_pkg::FUNC_SDEC, 64'h8000_0000_0000_0001);
    send_number(iat_pkg::FUNC_SDEC, 64'h7FFF_FFFF_FFFF_FFFF);
    send_number(iat_pkg::FUNC_HEX, 64'd0);
    send_number(iat_pkg::FUNC_HEX, 64'd10);
    send_number(iat_pkg::FUNC_HEX, 64'hFFFF_FFFF_FFFF_FFFF);
    send_number(iat_pkg::FUNC_HEX, 64'h0123_4567_89AB_CDEF);
    send_number(iat_pkg::FUNC_HEX, 64'h8000_0000_0000_0000);
    send_number(iat_pkg::FUNC_HEX_ALT, 64'd0);
    send_number(iat_pkg::FUNC_HEX_ALT, 64'hFEDC_BA98_7654_3210);
    send_number(iat_pkg::FUNC_HEX_ALT, 64'h0000_0000_000A_BCDE);
    send_random(RANDOM_CHUNK);

    src_idle  = 71;
    sink_idle = 13;
    send_random(RANDOM_CHUNK);

    src_idle  = 0;
    sink_idle = 0;
    hold_req  = 1'b1;
    send_random(RANDOM_CHUNK);
    in_valid <= 1'b0;

    while (sb.pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: integer_to_ascii_text_core.f
+incdir+src
src/iat_pkg.sv
src/iat_dp.sv
src/iat_ctrl.sv
src/integer_to_ascii_text_core.sv
dv/integer_to_ascii_text_core_test.sv
